// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the stereo sample FIFO.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: invariant");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/ssfr_pkg.sv =====
// Shared types, codes and widths of the stereo sample FIFO with underrun replay.
// No dependencies; every other RTL file but assert_macros.svh imports this package.
package ssfr_pkg;

  // Field widths
  localparam int SAMPLE_W  = 8;
  localparam int PAIR_W    = 2 * SAMPLE_W;
  localparam int STAT_W    = 3;
  localparam int FILL_W    = 10;
  localparam int BLK_IN_W  = 7;
  localparam int CAP_REG_W = 11;

  // Configuration port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam logic [1:0] REG_FLUSH_ON_FULL      = 2'd0;
  localparam logic [1:0] REG_REPLAY_ON_UNDERRUN = 2'd1;
  localparam logic [1:0] REG_FIFO_CAPACITY      = 2'd2;
  localparam logic [CAP_REG_W-1:0] CAP_RESET    = 11'd1024;

  // Default sizes
  localparam int DEF_FIFO_DEPTH = 1024;
  localparam int DEF_MAX_BLOCK  = 64;

  // Request action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DATA       = 3'd0,
    ST_REPLAY     = 3'd1,
    ST_SILENCE    = 3'd2,
    ST_UNDERRUN   = 3'd3,
    ST_WRITTEN    = 3'd4,
    ST_FULL       = 3'd5,
    ST_FRAME_DROP = 3'd6
  } status_t;

  // Commands to the sample ring
  typedef struct packed {
    logic              push;
    logic              pop;
    logic              flush;
    logic [PAIR_W-1:0] wdata;
  } ring_cmd_t;

  // Commands to the replay store
  typedef struct packed {
    logic clear;
    logic wr_en;
    logic rd_en;
  } replay_ctl_t;

  // One result item as held in the output queue
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic [STAT_W-1:0]          status;
    logic                       last;
    logic [FILL_W-1:0]          fill;
  } out_item_t;

endpackage

// ===== rtl/ssfr_req_if.sv =====
// Request channel of the stereo sample FIFO: valid/ready plus one request item.
// Depends on ssfr_pkg for field widths.
interface ssfr_req_if import ssfr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic                       end_of_frame;
  logic [BLK_IN_W-1:0]        block_pairs;

  modport source (
    output valid, action, left_sample, right_sample, end_of_frame, block_pairs,
    input  ready
  );
  modport sink (
    input  valid, action, left_sample, right_sample, end_of_frame, block_pairs,
    output ready
  );
endinterface

// ===== rtl/ssfr_res_if.sv =====
// Result channel of the stereo sample FIFO: valid/ready plus one result item.
// Depends on ssfr_pkg for field widths.
interface ssfr_res_if import ssfr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic [STAT_W-1:0]          status;
  logic                       last;
  logic [FILL_W-1:0]          fill_level;

  modport source (
    output valid, left_out, right_out, status, last, fill_level,
    input  ready
  );
  modport sink (
    input  valid, left_out, right_out, status, last, fill_level,
    output ready
  );
endinterface

// ===== rtl/ssfr_ring.sv =====
// Sample ring: FIFO_DEPTH x 16-bit memory with read/write pointers and pair count.
// Depends on ssfr_pkg; read data is registered, valid in the cycle after a pop.
module ssfr_ring import ssfr_pkg::*; #(
  parameter  int FIFO_DEPTH = DEF_FIFO_DEPTH,
  localparam int PTR_W      = $clog2(FIFO_DEPTH),
  localparam int CAP_W      = $clog2(FIFO_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  ring_cmd_t         cmd,
  input  logic [CAP_W-1:0]  cap_use,
  output logic [PTR_W-1:0]  pair_count,
  output logic [PAIR_W-1:0] rdata
);

  logic [PAIR_W-1:0] mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  read_pointer;
  logic [PTR_W-1:0]  write_pointer;

  // Advance a pointer, wrapping at the capacity in use
  function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p,
                                                input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] n;
    n = CAP_W'(p) + CAP_W'(1);
    return (n >= cap) ? '0 : PTR_W'(n);
  endfunction

  // Memory write on push, registered read on pop
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[write_pointer] <= cmd.wdata;
    end
    if (cmd.pop) begin
      rdata <= mem[read_pointer];
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer  <= '0;
      write_pointer <= '0;
      pair_count    <= '0;
    end else if (cmd.flush) begin
      read_pointer  <= '0;
      write_pointer <= '0;
      pair_count    <= '0;
    end else if (cmd.push) begin
      write_pointer <= step_ptr(write_pointer, cap_use);
      pair_count    <= pair_count + PTR_W'(1);
    end else if (cmd.pop) begin
      read_pointer  <= step_ptr(read_pointer, cap_use);
      pair_count    <= pair_count - PTR_W'(1);
    end
  end

endmodule

// ===== rtl/ssfr_replay.sv =====
// Replay store: MAX_BLOCK x 16-bit memory holding the last delivered block.
// Depends on ssfr_pkg; per-entry valid bits make unwritten entries read as zero.
module ssfr_replay import ssfr_pkg::*; #(
  parameter  int MAX_BLOCK = DEF_MAX_BLOCK,
  localparam int IDX_W     = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  replay_ctl_t       ctl,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [PAIR_W-1:0] wr_data,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic [PAIR_W-1:0] rd_data
);

  logic [PAIR_W-1:0]    mem [MAX_BLOCK];
  logic [MAX_BLOCK-1:0] valid;
  logic [PAIR_W-1:0]    mem_q;
  logic [PAIR_W-1:0]    fwd_data_q;
  logic                 fwd_q;
  logic                 hit_q;
  logic                 fwd;

  // A write and a read of the same entry in one cycle: take the write data
  assign fwd = ctl.wr_en && (wr_idx == rd_idx);

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (ctl.rd_en) begin
      mem_q      <= mem[rd_idx];
      fwd_q      <= fwd;
      fwd_data_q <= wr_data;
      hit_q      <= valid[rd_idx] | fwd;
    end
  end

  // Valid bits: clear all on silence, set on write
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.clear) begin
      valid <= '0;
    end else if (ctl.wr_en) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  // Entries never written since reset or silence read as zero
  assign rd_data = !hit_q ? '0 : (fwd_q ? fwd_data_q : mem_q);

endmodule

// ===== rtl/stereo_sample_fifo_with_underrun_replay_unit.sv =====
// Top level of the stereo sample FIFO with underrun replay: sequencer, output queue, APB.
// Depends on ssfr_pkg, ssfr_req_if, ssfr_res_if, ssfr_ring, ssfr_replay, assert_macros.svh.
//
//   channel   direction  handshake        payload
//   request   in         valid/ready      action, left/right_sample, end_of_frame, block_pairs
//   result    out        valid/ready      left/right_out, status, last, fill_level
//   apb       in/out     psel/penable     paddr, pwdata, prdata (pready tied high)
//
// A write item is issued as it is accepted; a read block is first decoded in the
// sequencer, then issues its pairs one at a time through the issue slot, holding while
// the queue and read stage are full. Results are offered after issue through the read
// stage and then the two-entry output queue.
// rst is synchronous; the sample ring needs no clearing pass and is ready at once.
// A stalled result side stops issue once the queue and the read stage hold two items.
`include "assert_macros.svh"
module stereo_sample_fifo_with_underrun_replay_unit import ssfr_pkg::*; #(
  parameter int FIFO_DEPTH = DEF_FIFO_DEPTH,
  parameter int MAX_BLOCK  = DEF_MAX_BLOCK
) (
  input  logic              clk,
  input  logic              rst,
  ssfr_req_if.sink          request,
  ssfr_res_if.source        result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CAP_W = $clog2(FIFO_DEPTH + 1);
  localparam int CMP_W = (CAP_W > CAP_REG_W) ? CAP_W : CAP_REG_W;
  localparam int BLK_W = $clog2(MAX_BLOCK + 1);
  localparam int IDX_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int CNT_W = (PTR_W > BLK_W) ? PTR_W : BLK_W;

  typedef enum logic {S_IDLE, S_BLOCK} state_t;
  typedef enum logic [1:0] {SRC_ZERO, SRC_RING, SRC_REPLAY} src_t;

  // Clamp a written capacity to the range the ring supports
  function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_REG_W-1:0] raw);
    logic [CMP_W-1:0] w;
    w = CMP_W'(raw);
    if (w < CMP_W'(2)) begin
      w = CMP_W'(2);
    end else if (w > CMP_W'(FIFO_DEPTH)) begin
      w = CMP_W'(FIFO_DEPTH);
    end
    return CAP_W'(w);
  endfunction

  // Configuration registers
  logic                 flush_on_full;
  logic                 replay_on_underrun;
  logic [CAP_REG_W-1:0] fifo_capacity;
  logic [CAP_W-1:0]     cap_use;
  logic [CAP_W-1:0]     cap_m1;
  logic                 cfg_wr;

  // Sequencer state
  state_t           state, state_next;
  logic             started, started_next;
  logic             dropping_frame, dropping_frame_next;
  status_t          blk_status, blk_status_next;
  logic [BLK_W-1:0] blk_n, blk_n_next;
  logic [BLK_W-1:0] blk_k, blk_k_next;

  // Issue of one result
  logic             iss_valid;
  status_t          iss_status;
  logic             iss_last;
  logic [PTR_W-1:0] iss_fill;
  src_t             iss_src;
  logic             can_issue;
  logic             req_acc;
  logic [BLK_W-1:0] req_n;
  logic             is_full;
  logic             blk_last;
  logic [2:0]       pend;

  // Read stage, in the cycle after issue
  logic              s1_valid;
  status_t           s1_status;
  logic              s1_last;
  logic [FILL_W-1:0] s1_fill;
  src_t              s1_src;
  logic [IDX_W-1:0]  s1_idx;
  logic [PAIR_W-1:0] s1_pair;

  // Output queue
  out_item_t  qbuf [2];
  logic [1:0] qcnt;
  logic       qrd;
  logic       qwr;
  logic       pop_out;
  out_item_t  q_head;

  // Submodule links
  ring_cmd_t         ring_cmd;
  logic [PTR_W-1:0]  pair_count;
  logic [PAIR_W-1:0] ring_rdata;
  replay_ctl_t       rp_ctl;
  logic              rp_clear;
  logic              rp_rd;
  logic [PAIR_W-1:0] rp_rdata;

  ssfr_ring #(.FIFO_DEPTH(FIFO_DEPTH)) u_ring (
    .clk        (clk),
    .rst        (rst),
    .cmd        (ring_cmd),
    .cap_use    (cap_use),
    .pair_count (pair_count),
    .rdata      (ring_rdata)
  );

  ssfr_replay #(.MAX_BLOCK(MAX_BLOCK)) u_replay (
    .clk     (clk),
    .rst     (rst),
    .ctl     (rp_ctl),
    .wr_idx  (s1_idx),
    .wr_data (ring_rdata),
    .rd_idx  (blk_k[IDX_W-1:0]),
    .rd_data (rp_rdata)
  );

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      flush_on_full      <= 1'b1;
      replay_on_underrun <= 1'b0;
      fifo_capacity      <= CAP_RESET;
      cap_use            <= clamp_cap(CAP_RESET);
      cap_m1             <= clamp_cap(CAP_RESET) - CAP_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_FLUSH_ON_FULL:      flush_on_full <= pwdata[0];
        REG_REPLAY_ON_UNDERRUN: replay_on_underrun <= pwdata[0];
        REG_FIFO_CAPACITY: begin
          fifo_capacity <= pwdata[CAP_REG_W-1:0];
          cap_use       <= clamp_cap(pwdata[CAP_REG_W-1:0]);
          cap_m1        <= clamp_cap(pwdata[CAP_REG_W-1:0]) - CAP_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FLUSH_ON_FULL:      prdata = APB_DW'(flush_on_full);
      REG_REPLAY_ON_UNDERRUN: prdata = APB_DW'(replay_on_underrun);
      REG_FIFO_CAPACITY:      prdata = APB_DW'(fifo_capacity);
      default:                prdata = '0;
    endcase
  end

  // Issue slot: queue plus read stage never hold more than two items
  assign pop_out   = result.valid && result.ready;
  assign pend      = {1'b0, qcnt} + {2'b00, s1_valid};
  assign can_issue = (pend <= 3'd1) || ((pend == 3'd2) && pop_out);
  assign request.ready = (state == S_IDLE) && can_issue;
  assign req_acc   = request.valid && request.ready;

  // Request decode helpers
  assign req_n    = (request.block_pairs > BLK_IN_W'(MAX_BLOCK)) ?
                    BLK_W'(MAX_BLOCK) : BLK_W'(request.block_pairs);
  assign is_full  = CAP_W'(pair_count) >= cap_m1;
  assign blk_last = (blk_k + BLK_W'(1)) == blk_n;

  // Sequencer: decode items, issue one result per free slot
  always_comb begin
    state_next          = state;
    started_next        = started;
    dropping_frame_next = dropping_frame;
    blk_status_next     = blk_status;
    blk_n_next          = blk_n;
    blk_k_next          = blk_k;
    iss_valid           = 1'b0;
    iss_status          = ST_WRITTEN;
    iss_last            = 1'b0;
    iss_fill            = pair_count;
    iss_src             = SRC_ZERO;
    ring_cmd            = '{push: 1'b0, pop: 1'b0, flush: 1'b0,
                            wdata: {request.left_sample, request.right_sample}};
    rp_clear            = 1'b0;
    rp_rd               = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_acc && (request.action == ACT_WRITE)) begin
          started_next = 1'b1;
          iss_valid    = 1'b1;
          iss_last     = 1'b1;
          if (dropping_frame) begin
            iss_status = ST_FRAME_DROP;
            if (request.end_of_frame) begin
              dropping_frame_next = 1'b0;
            end
          end else if (is_full) begin
            iss_status = ST_FULL;
            if (flush_on_full) begin
              ring_cmd.flush = 1'b1;
              iss_fill       = '0;
            end
            dropping_frame_next = !request.end_of_frame;
          end else begin
            ring_cmd.push = 1'b1;
            iss_status    = ST_WRITTEN;
            iss_fill      = pair_count + PTR_W'(1);
          end
        end else if (req_acc && (req_n != '0)) begin
          blk_n_next = req_n;
          blk_k_next = '0;
          if (!started) begin
            rp_clear        = 1'b1;
            state_next      = S_BLOCK;
            blk_status_next = ST_SILENCE;
          end else if (CNT_W'(pair_count) < CNT_W'(req_n)) begin
            if (replay_on_underrun) begin
              state_next      = S_BLOCK;
              blk_status_next = ST_REPLAY;
            end else begin
              iss_valid  = 1'b1;
              iss_status = ST_UNDERRUN;
              iss_last   = 1'b1;
            end
          end else begin
            state_next      = S_BLOCK;
            blk_status_next = ST_DATA;
          end
        end
      end
      S_BLOCK: begin
        if (can_issue) begin
          iss_valid  = 1'b1;
          iss_status = blk_status;
          iss_last   = blk_last;
          blk_k_next = blk_k + BLK_W'(1);
          if (blk_last) begin
            state_next = S_IDLE;
          end
          if (blk_status == ST_DATA) begin
            ring_cmd.pop = 1'b1;
            iss_src      = SRC_RING;
            iss_fill     = pair_count - PTR_W'(1);
          end else if (blk_status == ST_REPLAY) begin
            rp_rd   = 1'b1;
            iss_src = SRC_REPLAY;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      started        <= 1'b0;
      dropping_frame <= 1'b0;
      blk_status     <= ST_DATA;
      blk_n          <= '0;
      blk_k          <= '0;
    end else begin
      state          <= state_next;
      started        <= started_next;
      dropping_frame <= dropping_frame_next;
      blk_status     <= blk_status_next;
      blk_n          <= blk_n_next;
      blk_k          <= blk_k_next;
    end
  end

  // Read stage: hold result fields while the memories answer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= iss_valid;
    end
    s1_status <= iss_status;
    s1_last   <= iss_last;
    s1_fill   <= FILL_W'(iss_fill);
    s1_src    <= iss_src;
    s1_idx    <= blk_k[IDX_W-1:0];
  end

  // Select pair data; save popped pairs for replay
  always_comb begin
    unique case (s1_src)
      SRC_RING:   s1_pair = ring_rdata;
      SRC_REPLAY: s1_pair = rp_rdata;
      default:    s1_pair = '0;
    endcase
  end

  assign rp_ctl = '{clear: rp_clear,
                    wr_en: s1_valid && (s1_src == SRC_RING),
                    rd_en: rp_rd};

  // Output queue: two entries, head drives the result channel
  always_ff @(posedge clk) begin
    if (rst) begin
      qcnt <= '0;
      qrd  <= 1'b0;
      qwr  <= 1'b0;
    end else begin
      if (s1_valid) begin
        qwr <= !qwr;
      end
      if (pop_out) begin
        qrd <= !qrd;
      end
      qcnt <= qcnt + {1'b0, s1_valid} - {1'b0, pop_out};
    end
    if (s1_valid) begin
      qbuf[qwr] <= '{left:   s1_pair[PAIR_W-1:SAMPLE_W],
                     right:  s1_pair[SAMPLE_W-1:0],
                     status: s1_status,
                     last:   s1_last,
                     fill:   s1_fill};
    end
  end

  assign q_head            = qbuf[qrd];
  assign result.valid      = (qcnt != '0);
  assign result.left_out   = q_head.left;
  assign result.right_out  = q_head.right;
  assign result.status     = q_head.status;
  assign result.last       = q_head.last;
  assign result.fill_level = q_head.fill;

  // Checks
  `ASSERT_ALWAYS(a_queue_bound, clk, rst, pend <= 3'd2)
  `ASSERT_IMPLIES(a_pop_nonempty, clk, rst, ring_cmd.pop, pair_count != '0)
  `ASSERT_ALWAYS(a_ring_one_op, clk, rst, !(ring_cmd.push && ring_cmd.pop))
  `ASSERT_NEXT(a_last_to_idle, clk, rst, iss_valid && iss_last, state == S_IDLE)

endmodule

// ===== bench/tb.sv =====
// Testbench for the stereo sample FIFO with underrun replay: an item-level predictor and
// scoreboard on the request/result channels, with register writes over APB between phases.
// Depends on ssfr_pkg, ssfr_req_if, ssfr_res_if and stereo_sample_fifo_with_underrun_replay_unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssfr_pkg::*;

  localparam int FIFO_DEPTH   = DEF_FIFO_DEPTH;
  localparam int MAX_BLOCK    = DEF_MAX_BLOCK;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 16;
  localparam int SETTLE_TICKS = 12;

  typedef struct {
    logic                       action;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       eof;
    logic [BLK_IN_W-1:0]        blk;
  } req_item_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ssfr_req_if request_ch();
  ssfr_res_if result_ch();

  stereo_sample_fifo_with_underrun_replay_unit uut (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted copy of the FIFO state and its registers
  logic              cfg_flush  = 1'b1;
  logic              cfg_replay = 1'b0;
  logic [CAP_REG_W-1:0] cfg_cap = CAP_RESET;
  logic [PAIR_W-1:0] ring_mem [FIFO_DEPTH];
  logic [PAIR_W-1:0] replay_mem [MAX_BLOCK] = '{default: '0};
  int                rd_ptr = 0;
  int                wr_ptr = 0;
  int                pairs_held = 0;
  logic              has_started = 1'b0;
  logic              frame_dropping = 1'b0;

  out_item_t expected_results[$];
  req_item_t pending_items[$];
  out_item_t result_want;
  int        items_queued = 0;
  int        items_accepted = 0;
  int        results_checked = 0;
  int        fail_count = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;

  function automatic int ring_size(logic [CAP_REG_W-1:0] cap);
    if (cap < 2) return 2;
    if (cap > FIFO_DEPTH) return FIFO_DEPTH;
    return cap;
  endfunction

  function automatic int next_slot(int p);
    return (p + 1 >= ring_size(cfg_cap)) ? 0 : p + 1;
  endfunction

  function automatic void push_result(logic [PAIR_W-1:0] pair, status_t st, logic is_last);
    out_item_t r;
    r.left   = pair[PAIR_W-1:SAMPLE_W];
    r.right  = pair[SAMPLE_W-1:0];
    r.status = st;
    r.last   = is_last;
    r.fill   = pairs_held[FILL_W-1:0];
    expected_results.push_back(r);
  endfunction

  // Advance the predicted state by one accepted item and queue its results
  function automatic void predict_request(req_item_t it);
    int n;
    logic [PAIR_W-1:0] pair;
    if (it.action == ACT_WRITE) begin
      has_started = 1'b1;
      if (frame_dropping) begin
        if (it.eof) frame_dropping = 1'b0;
        push_result('0, ST_FRAME_DROP, 1'b1);
      end else if (pairs_held >= ring_size(cfg_cap) - 1) begin
        if (cfg_flush) begin
          rd_ptr = 0;
          wr_ptr = 0;
          pairs_held = 0;
        end
        frame_dropping = !it.eof;
        push_result('0, ST_FULL, 1'b1);
      end else begin
        ring_mem[wr_ptr] = {it.left, it.right};
        wr_ptr = next_slot(wr_ptr);
        pairs_held++;
        push_result('0, ST_WRITTEN, 1'b1);
      end
      return;
    end
    n = (it.blk > MAX_BLOCK) ? MAX_BLOCK : int'(it.blk);
    if (n == 0) return;
    if (!has_started) begin
      // silence before the first write, and forget any old block
      foreach (replay_mem[k]) replay_mem[k] = '0;
      for (int k = 0; k < n; k++) push_result('0, ST_SILENCE, k == n - 1);
    end else if (pairs_held < n) begin
      if (cfg_replay) begin
        for (int k = 0; k < n; k++) push_result(replay_mem[k], ST_REPLAY, k == n - 1);
      end else begin
        push_result('0, ST_UNDERRUN, 1'b1);
      end
    end else begin
      for (int k = 0; k < n; k++) begin
        pair = ring_mem[rd_ptr];
        rd_ptr = next_slot(rd_ptr);
        pairs_held--;
        replay_mem[k] = pair;
        push_result(pair, ST_DATA, k == n - 1);
      end
    end
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Drive the request channel from the pending queue, with random gaps
  always @(posedge clk) begin
    if (rst) begin
      request_ch.valid <= 1'b0;
    end else if (!request_ch.valid || request_ch.ready) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        request_ch.action       <= pending_items[0].action;
        request_ch.left_sample  <= pending_items[0].left;
        request_ch.right_sample <= pending_items[0].right;
        request_ch.end_of_frame <= pending_items[0].eof;
        request_ch.block_pairs  <= pending_items[0].blk;
        request_ch.valid        <= 1'b1;
        void'(pending_items.pop_front());
      end else begin
        request_ch.valid <= 1'b0;
      end
    end
  end

  // Predict results for every accepted request item
  always @(posedge clk) begin
    if (!rst && request_ch.valid && request_ch.ready) begin
      predict_request('{request_ch.action, request_ch.left_sample, request_ch.right_sample,
                        request_ch.end_of_frame, request_ch.block_pairs});
      items_accepted++;
    end
  end

  // Check accepted result items against the oldest prediction; stall at random
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with none expected: status %0d", result_ch.status);
          fail_count++;
        end else begin
          result_want = expected_results.pop_front();
          check_field("left_out", result_want.left, result_ch.left_out);
          check_field("right_out", result_want.right, result_ch.right_out);
          check_field("status", result_want.status, result_ch.status);
          check_field("last", result_want.last, result_ch.last);
          check_field("fill_level", result_want.fill, result_ch.fill_level);
          results_checked++;
        end
      end
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic queue_item(req_item_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_write(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
                             logic eof);
    queue_item('{ACT_WRITE, l, r, eof, BLK_IN_W'($urandom)});
  endtask

  task automatic queue_read(int n);
    queue_item('{ACT_READ, SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'($urandom),
                 BLK_IN_W'(n)});
  endtask

  // Wait until every item is taken and every result seen, then let the pipeline empty
  task automatic settle();
    do @(negedge clk);
    while (items_accepted != items_queued || expected_results.size() != 0);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [APB_DW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_FLUSH_ON_FULL:      cfg_flush  = value[0];
      REG_REPLAY_ON_UNDERRUN: cfg_replay = value[0];
      REG_FIFO_CAPACITY:      cfg_cap    = value[CAP_REG_W-1:0];
      default: ;
    endcase
  endtask

  // Random traffic: mostly whole frames of writes and sized reads, plus some noise
  task automatic queue_traffic(int count, logic [CAP_REG_W-1:0] cap);
    int frame_left;
    int pick;
    int read_lim;
    req_item_t it;
    frame_left = 0;
    read_lim = (ring_size(cap) < 16) ? ring_size(cap) : 16;
    repeat (count) begin
      it.left   = SAMPLE_W'($urandom);
      it.right  = SAMPLE_W'($urandom);
      it.eof    = 1'($urandom);
      it.blk    = BLK_IN_W'($urandom);
      it.action = ACT_WRITE;
      pick = $urandom_range(99);
      if (pick < 55) begin
        if (frame_left == 0) frame_left = $urandom_range(1, 6);
        frame_left--;
        it.eof = (frame_left == 0);
      end else if (pick < 90) begin
        it.action = ACT_READ;
        it.blk    = BLK_IN_W'($urandom_range(1, read_lim));
      end else if (pick < 95) begin
        it.action = ACT_READ;
        it.blk    = BLK_IN_W'($urandom_range(0, 127));
      end
      queue_item(it);
    end
  endtask

  initial begin
    #3000000;
    $display("stereo_sample_fifo_with_underrun_replay_unit test failed");
    $finish;
  end

  initial begin
    logic              ph_flush;
    logic              ph_replay;
    logic [CAP_REG_W-1:0] ph_cap;
    rst = 1'b1;
    request_ch.valid        = 1'b0;
    request_ch.action       = ACT_WRITE;
    request_ch.left_sample  = '0;
    request_ch.right_sample = '0;
    request_ch.end_of_frame = 1'b0;
    request_ch.block_pairs  = '0;
    result_ch.ready = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reads before any write give silence; an empty block gives nothing
    queue_read(3);
    queue_read(0);
    settle();
    apb_write(REG_FIFO_CAPACITY, 3);
    apb_write(REG_REPLAY_ON_UNDERRUN, 1);

    // Fill to full, flush on the overflow, then drop the rest of that frame
    queue_write(127, -128, 1'b0);
    queue_write(-128, 127, 1'b0);
    queue_write(0, -1, 1'b0);
    queue_write(1, 1, 1'b0);
    queue_write(2, 2, 1'b1);
    // Deliver a short block, then replay it padded with zeros, then oversize
    queue_write(-1, 0, 1'b1);
    queue_write(85, -86, 1'b1);
    queue_read(2);
    queue_read(5);
    queue_read(127);
    settle();
    apb_write(REG_REPLAY_ON_UNDERRUN, 0);
    queue_read(1);
    settle();
    apb_write(REG_FLUSH_ON_FULL, 0);

    // Full without flush: keep contents, drop a frame, resume on its end
    queue_write(-42, 42, 1'b1);
    queue_write(17, -17, 1'b1);
    queue_write(3, 3, 1'b1);
    queue_write(4, 4, 1'b0);
    queue_write(5, 5, 1'b1);
    queue_read(2);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      // Empty the FIFO so that a new capacity starts with both pointers together
      while (pairs_held > 0) begin
        queue_read((pairs_held > MAX_BLOCK) ? MAX_BLOCK : pairs_held);
        settle();
      end
      case (ph)
        0: begin ph_flush = 1; ph_replay = 1; ph_cap = 4;    end
        1: begin ph_flush = 0; ph_replay = 0; ph_cap = 8;    end
        2: begin ph_flush = 1; ph_replay = 1; ph_cap = 0;    end
        3: begin ph_flush = 0; ph_replay = 1; ph_cap = 2047; end
        4: begin ph_flush = 1; ph_replay = 0; ph_cap = 16;   end
        5: begin ph_flush = 0; ph_replay = 1; ph_cap = 5;    end
        6: begin ph_flush = 1; ph_replay = 1; ph_cap = 1024; end
        default: begin ph_flush = 0; ph_replay = 0; ph_cap = 1; end
      endcase
      apb_write(REG_FLUSH_ON_FULL, ph_flush);
      apb_write(REG_REPLAY_ON_UNDERRUN, ph_replay);
      apb_write(REG_FIFO_CAPACITY, ph_cap);
      // Rotate idling: none, sender gaps, receiver stalls, both
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      queue_traffic(PHASE_ITEMS, ph_cap);
    end
    settle();

    $display("Covered %0d request items and %0d result items over %0d register settings,",
             items_accepted, results_checked, NUM_PHASES + 4);
    $display("with silence, full/flush, frame drop, underrun and replay paths exercised.");
    if (fail_count == 0) begin
      $display("stereo_sample_fifo_with_underrun_replay_unit test passed");
    end else begin
      $display("stereo_sample_fifo_with_underrun_replay_unit test failed");
    end
    $finish;
  end

endmodule
